### design/n2a_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the number-to-ASCII formatter.
// No dependencies; every other design file depends on this package.
package n2a_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int CNT_W      = 6;   // holds the bit count of a 32-bit operand
   localparam int NDIG_W     = 4;   // holds the digit count, up to NUM_DIGITS

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      MODE_S16 = 3'd0,
      MODE_U16 = 3'd1,
      MODE_S32 = 3'd2,
      MODE_U32 = 3'd3,
      MODE_HEX = 3'd4,
      MODE_CHR = 3'd5
   } n2a_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } n2a_state_type;

   // Load command for the character serializer.
   typedef struct packed {
      logic [BCD_W-1:0]  digits;    // most significant digit in the top nibble
      logic [NDIG_W-1:0] ndig;      // digits to send out
      logic              skip;      // drop leading zero digits
      logic              pfx_en;    // send pfx_char before the digits
      logic [CHAR_W-1:0] pfx_char;
   } n2a_ser_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } n2a_conv_sts_type;

   typedef struct packed {
      logic busy;
   } n2a_ser_sts_type;

endpackage

### design/n2a_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and result characters.
// Depends on n2a_pkg for field widths.
interface n2a_req_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   mode;
   logic [n2a_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface n2a_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [n2a_pkg::CHAR_W-1:0]   ascii_char;
   logic                         last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

### design/n2a_bin2bcd.sv
`timescale 1ns / 1ps
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on n2a_pkg.
module n2a_bin2bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [n2a_pkg::VALUE_W-1:0]   bits_in,   // operand, left aligned
   input  logic [n2a_pkg::CNT_W-1:0]     nbits,
   output n2a_pkg::n2a_conv_sts_type     sts,
   output logic [n2a_pkg::BCD_W-1:0]     bcd
);
   import n2a_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in, adj;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // Add three to every digit of five or more, then shift one bit in.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (load) begin
         bin_in  = bits_in;
         bcd_in  = '0;
         cnt_in  = nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in  = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign bcd      = bcd_ff;

endmodule

### design/n2a_char_ser.sv
`timescale 1ns / 1ps
// Character serializer: shifts one digit per cycle into a free output register.
// Depends on n2a_pkg and n2a_rsp_if.
module n2a_char_ser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  n2a_pkg::n2a_ser_cmd_type  cmd,
   output n2a_pkg::n2a_ser_sts_type  sts,
   n2a_rsp_if.source                 rsp_ch
);
   import n2a_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + wide;
      end else begin
         digit_char = CHAR_UPPER_A + wide - 8'd10;
      end
   endfunction

   logic [BCD_W-1:0]   digits_ff, digits_in;
   logic [NDIG_W-1:0]  ndig_ff, ndig_in;
   logic               skip_ff, skip_in;
   logic               pfx_ff, pfx_in;
   logic [CHAR_W-1:0]  pfx_char_ff, pfx_char_in;
   logic               busy_ff, busy_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic [DIGIT_W-1:0] top_digit;
   logic               out_free;

   assign top_digit = digits_ff[BCD_W-1 -: DIGIT_W];
   assign out_free  = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      digits_in    = digits_ff;
      ndig_in      = ndig_ff;
      skip_in      = skip_ff;
      pfx_in       = pfx_ff;
      pfx_char_in  = pfx_char_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         digits_in   = cmd.digits;
         ndig_in     = cmd.ndig;
         skip_in     = cmd.skip;
         pfx_in      = cmd.pfx_en;
         pfx_char_in = cmd.pfx_char;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         if (pfx_ff) begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = pfx_char_ff;
               out_last_in  = (ndig_ff == '0);
               pfx_in       = 1'b0;
               busy_in      = (ndig_ff != '0);
            end
         end else if (skip_ff && top_digit == '0 && ndig_ff > NDIG_W'(1)) begin
            // drop a leading zero, keep at least one digit
            digits_in = {digits_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            ndig_in   = ndig_ff - 1'b1;
         end else if (out_free) begin
            out_valid_in = 1'b1;
            out_char_in  = digit_char(top_digit);
            out_last_in  = (ndig_ff == NDIG_W'(1));
            digits_in    = {digits_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            ndig_in      = ndig_ff - 1'b1;
            skip_in      = 1'b0;
            busy_in      = (ndig_ff != NDIG_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      ndig_ff     <= ndig_in;
      skip_ff     <= skip_in;
      pfx_char_ff <= pfx_char_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         pfx_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pfx_ff       <= pfx_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign sts.busy          = busy_ff;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.ascii_char = out_char_ff;
   assign rsp_ch.last_char  = out_last_ff;

endmodule

### design/number_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
// Flow: a decimal request loads the bit-serial BCD converter (one operand bit per cycle);
// its digits then go to the serializer. Hex and char requests go to the serializer at once.
// Characters leave at one per cycle while the output register is free; dropped leading
// zeros hold them back. One request is in flight at a time: the next request transfer
// comes only after the final character enters the output register and the core is idle.
// Reset: synchronous, active high; clears the control state only.
module number_to_ascii_formatter_core (
   input  logic      clock,
   input  logic      reset,
   n2a_req_if.sink   req_ch,
   n2a_rsp_if.source rsp_ch
);
   import n2a_pkg::*;

   n2a_state_type    state_ff, state_in;
   logic             neg_ff, neg_in;
   logic             wide_ff, wide_in;

   logic             accept;
   logic             mode_ok;
   logic             is_dec;
   logic             dec_neg;
   logic             dec_wide;
   logic [VALUE_W-1:0] mag;
   n2a_ser_cmd_type  direct_cmd;
   n2a_ser_cmd_type  dec_cmd;
   n2a_ser_cmd_type  ser_cmd;
   logic             conv_load;
   logic             ser_load;
   logic [VALUE_W-1:0] conv_bits;
   logic [CNT_W-1:0] conv_nbits;
   n2a_conv_sts_type conv_sts;
   n2a_ser_sts_type  ser_sts;
   logic [BCD_W-1:0] bcd;

   assign accept = req_ch.valid && req_ch.ready;

   // Decode the mode: take the magnitude for decimal modes, build the command for the
   // modes that need no conversion.
   always_comb begin
      mode_ok    = 1'b1;
      is_dec     = 1'b0;
      dec_neg    = 1'b0;
      dec_wide   = 1'b0;
      mag        = req_ch.value;
      direct_cmd = '0;
      unique case (req_ch.mode)
         MODE_S16: begin
            is_dec  = 1'b1;
            dec_neg = req_ch.value[15];
            mag     = {16'b0, req_ch.value[15] ? (16'b0 - req_ch.value[15:0])
                                               : req_ch.value[15:0]};
         end
         MODE_U16: begin
            is_dec = 1'b1;
            mag    = {16'b0, req_ch.value[15:0]};
         end
         MODE_S32: begin
            is_dec   = 1'b1;
            dec_wide = 1'b1;
            dec_neg  = req_ch.value[VALUE_W-1];
            mag      = req_ch.value[VALUE_W-1] ? ('0 - req_ch.value) : req_ch.value;
         end
         MODE_U32: begin
            is_dec   = 1'b1;
            dec_wide = 1'b1;
         end
         MODE_HEX: begin
            direct_cmd.digits = {req_ch.value[15:0], {(BCD_W-16){1'b0}}};
            direct_cmd.ndig   = NDIG_W'(4);
         end
         MODE_CHR: begin
            direct_cmd.pfx_en   = 1'b1;
            direct_cmd.pfx_char = req_ch.value[CHAR_W-1:0];
         end
         default: begin
            // unused mode codes: drop the request
            mode_ok = 1'b0;
         end
      endcase
   end

   // Left align the operand so the converter always shifts from the top bit.
   assign conv_bits  = dec_wide ? mag : {mag[15:0], 16'b0};
   assign conv_nbits = dec_wide ? CNT_W'(32) : CNT_W'(16);

   always_comb begin
      dec_cmd          = '0;
      dec_cmd.digits   = wide_ff ? bcd : {bcd[19:0], {(BCD_W-20){1'b0}}};
      dec_cmd.ndig     = wide_ff ? NDIG_W'(NUM_DIGITS) : NDIG_W'(5);
      dec_cmd.skip     = 1'b1;
      dec_cmd.pfx_en   = neg_ff;
      dec_cmd.pfx_char = CHAR_MINUS;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && mode_ok) begin
               state_in = is_dec ? ST_CONV : ST_EMIT;
            end
         end
         ST_CONV: begin
            if (conv_sts.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ser_sts.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the controller
   always_comb begin
      req_ch.ready = 1'b0;
      conv_load    = 1'b0;
      ser_load     = 1'b0;
      ser_cmd      = direct_cmd;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            conv_load    = accept && mode_ok && is_dec;
            ser_load     = accept && mode_ok && !is_dec;
         end
         ST_CONV: begin
            ser_load = conv_sts.done;
            ser_cmd  = dec_cmd;
         end
         ST_EMIT: begin
            ser_load = 1'b0;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Hold sign and width of the request until the digits are ready.
   assign neg_in  = conv_load ? dec_neg : neg_ff;
   assign wide_in = conv_load ? dec_wide : wide_ff;

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      wide_ff <= wide_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   n2a_bin2bcd u_bin2bcd (
      .clock   (clock),
      .reset   (reset),
      .load    (conv_load),
      .bits_in (conv_bits),
      .nbits   (conv_nbits),
      .sts     (conv_sts),
      .bcd     (bcd)
   );

   n2a_char_ser u_char_ser (
      .clock  (clock),
      .reset  (reset),
      .load   (ser_load),
      .cmd    (ser_cmd),
      .sts    (ser_sts),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTHESIS
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_sts.done |-> state_ff == ST_CONV)
      else $error("converter finished outside conversion");
   a_ser_busy_in_emit: assert property (@(posedge clock) disable iff (reset)
      ser_sts.busy |-> state_ff == ST_EMIT)
      else $error("serializer busy outside emit state");
   a_run_not_ended: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last_char) |-> ser_sts.busy)
      else $error("run ended without a last character");
`endif

endmodule
